// File: rtl/cdu_pkg.sv
package cdu_pkg;

   typedef enum logic [1:0] {
      MODE_VALIDATE = 2'd0,
      MODE_PREV     = 2'd1,
      MODE_NEXT     = 2'd2,
      MODE_ORDINAL  = 2'd3
   } mode_type;

   localparam logic [3:0]  MONTHS_PER_YEAR = 4'd12;
   localparam logic [3:0]  MONTH_FEB       = 4'd2;
   localparam logic [4:0]  DECEMBER_DAYS   = 5'd31;
   localparam logic [15:0] YEAR_MAX        = 16'h7FFF;

   // The quotient y / 25 is (y * 5243) >> 17, exact for all 15-bit y.
   localparam logic [12:0] DIV25_MUL   = 13'd5243;
   localparam int          DIV25_SHIFT = 17;
   localparam logic [4:0]  DIV25_BASE  = 5'd25;

   typedef struct packed {
      mode_type           mode;
      logic [4:0]         day;
      logic [3:0]         month;
      logic signed [15:0] year;
   } req_type;

   typedef struct packed {
      logic       vld;
      req_type    req;
      logic [10:0] quot25;
   } s1_type;

   typedef struct packed {
      logic       vld;
      req_type    req;
      logic       ok;
      logic       leap;
      logic [4:0] mlen;
      logic [4:0] prev_mlen;
   } s2_type;

   typedef struct packed {
      logic               vld;
      logic               date_valid;
      logic [4:0]         result_day;
      logic [3:0]         result_month;
      logic signed [15:0] result_year;
      logic [8:0]         ordinal_day;
   } rsp_type;

   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      len = 5'd0;
      unique case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = leap ? 5'd29 : 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

   function automatic logic [8:0] days_before(input logic [3:0] m);
      logic [8:0] cnt;
      cnt = 9'd0;
      unique case (m)
         4'd1:    cnt = 9'd0;
         4'd2:    cnt = 9'd31;
         4'd3:    cnt = 9'd59;
         4'd4:    cnt = 9'd90;
         4'd5:    cnt = 9'd120;
         4'd6:    cnt = 9'd151;
         4'd7:    cnt = 9'd181;
         4'd8:    cnt = 9'd212;
         4'd9:    cnt = 9'd243;
         4'd10:   cnt = 9'd273;
         4'd11:   cnt = 9'd304;
         4'd12:   cnt = 9'd334;
         default: cnt = 9'd0;
      endcase
      return cnt;
   endfunction

endpackage

// File: rtl/cdu_div25.sv
module cdu_div25 (
   input  logic              clock,
   input  logic              reset,
   input  logic              beat_in,
   input  cdu_pkg::req_type  req,
   output cdu_pkg::s1_type   s1
);

   logic             vld_ff;
   cdu_pkg::req_type req_ff;
   logic [10:0]      quot_ff;
   logic [10:0]      quot_in;
   logic [27:0]      prod;

   assign prod    = {13'd0, req.year[14:0]} * {15'd0, cdu_pkg::DIV25_MUL};
   assign quot_in = prod[27:cdu_pkg::DIV25_SHIFT];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= beat_in;
      end
      req_ff  <= req;
      quot_ff <= quot_in;
   end

   assign s1.vld    = vld_ff;
   assign s1.req    = req_ff;
   assign s1.quot25 = quot_ff;

endmodule

// File: rtl/cdu_check.sv
module cdu_check (
   input  logic             clock,
   input  logic             reset,
   input  cdu_pkg::s1_type  s1,
   output cdu_pkg::s2_type  s2
);

   cdu_pkg::s2_type s2_ff;
   cdu_pkg::s2_type s2_in;
   logic [15:0]     back25;
   logic            div4;
   logic            div16;
   logic            div25;

   assign back25 = {5'd0, s1.quot25} * {11'd0, cdu_pkg::DIV25_BASE};
   assign div4   = (s1.req.year[1:0] == 2'd0);
   assign div16  = (s1.req.year[3:0] == 4'd0);
   assign div25  = (back25[14:0] == s1.req.year[14:0]);

   always_comb begin
      s2_in           = '0;
      s2_in.vld       = s1.vld;
      s2_in.req       = s1.req;
      s2_in.leap      = div4 && (!div25 || div16);
      s2_in.mlen      = cdu_pkg::month_len(s1.req.month, s2_in.leap);
      s2_in.prev_mlen = cdu_pkg::month_len(s1.req.month - 4'd1, s2_in.leap);
      s2_in.ok        = !s1.req.year[15]
                        && (s1.req.month != 4'd0)
                        && (s1.req.month <= cdu_pkg::MONTHS_PER_YEAR)
                        && (s1.req.day != 5'd0)
                        && (s1.req.day <= s2_in.mlen);
   end

   always_ff @(posedge clock) begin
      s2_ff <= s2_in;
      if (reset) begin
         s2_ff.vld <= 1'b0;
      end
   end

   assign s2 = s2_ff;

endmodule

// File: rtl/cdu_step.sv
module cdu_step (
   input  logic             clock,
   input  logic             reset,
   input  cdu_pkg::s2_type  s2,
   output cdu_pkg::rsp_type rsp
);

   cdu_pkg::rsp_type rsp_ff;
   cdu_pkg::rsp_type rsp_in;
   logic             ok;

   always_comb begin
      ok                  = s2.ok;
      rsp_in              = '0;
      rsp_in.vld          = s2.vld;
      rsp_in.result_day   = s2.req.day;
      rsp_in.result_month = s2.req.month;
      rsp_in.result_year  = s2.req.year;
      if (ok) begin
         unique case (s2.req.mode)
            cdu_pkg::MODE_PREV: begin
               if (s2.req.day > 5'd1) begin
                  rsp_in.result_day = s2.req.day - 5'd1;
               end else if (s2.req.month > 4'd1) begin
                  rsp_in.result_month = s2.req.month - 4'd1;
                  rsp_in.result_day   = s2.prev_mlen;
               end else begin
                  rsp_in.result_month = cdu_pkg::MONTHS_PER_YEAR;
                  rsp_in.result_day   = cdu_pkg::DECEMBER_DAYS;
                  rsp_in.result_year  = s2.req.year - 16'sd1;
               end
            end
            cdu_pkg::MODE_NEXT: begin
               if (s2.req.day < s2.mlen) begin
                  rsp_in.result_day = s2.req.day + 5'd1;
               end else if (s2.req.month < cdu_pkg::MONTHS_PER_YEAR) begin
                  rsp_in.result_day   = 5'd1;
                  rsp_in.result_month = s2.req.month + 4'd1;
               end else if (s2.req.year == cdu_pkg::YEAR_MAX) begin
                  ok = 1'b0;
               end else begin
                  rsp_in.result_day   = 5'd1;
                  rsp_in.result_month = 4'd1;
                  rsp_in.result_year  = s2.req.year + 16'sd1;
               end
            end
            cdu_pkg::MODE_ORDINAL: begin
               rsp_in.ordinal_day = cdu_pkg::days_before(s2.req.month)
                                    + {4'd0, s2.req.day}
                                    + {8'd0, s2.leap && (s2.req.month > cdu_pkg::MONTH_FEB)};
            end
            cdu_pkg::MODE_VALIDATE: begin
            end
         endcase
      end
      rsp_in.date_valid = ok;
      if (!ok) begin
         rsp_in.result_day   = 5'd0;
         rsp_in.result_month = 4'd0;
         rsp_in.result_year  = 16'sd0;
         rsp_in.ordinal_day  = 9'd0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         rsp_ff.vld <= 1'b0;
      end
   end

   assign rsp = rsp_ff;

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ff.vld && !rsp_ff.date_valid |->
         rsp_ff.result_day == 5'd0 && rsp_ff.result_month == 4'd0
         && rsp_ff.result_year == 16'sd0 && rsp_ff.ordinal_day == 9'd0)
      else $error("invalid result carries nonzero fields");

   a_valid_date: assert property (@(posedge clock) disable iff (reset)
      rsp_ff.vld && rsp_ff.date_valid |->
         rsp_ff.result_day != 5'd0 && rsp_ff.result_month != 4'd0
         && rsp_ff.result_month <= cdu_pkg::MONTHS_PER_YEAR)
      else $error("valid result with out-of-range day or month");

   a_ordinal_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ff.vld && rsp_ff.ordinal_day != 9'd0 |->
         rsp_ff.date_valid && rsp_ff.ordinal_day <= 9'd366)
      else $error("ordinal day out of range");

endmodule

// File: rtl/calendar_date_unit_top.sv
// Channel    Handshake          Ports
// request    start, busy        req_mode, req_day, req_month, req_year
// response   rsp_strobe         rsp_date_valid, rsp_result_day, rsp_result_month,
//                               rsp_result_year, rsp_ordinal_day
//
// A beat is accepted on any edge with start high and busy low, one per cycle.
// Its result is on the rsp_ ports for one cycle.
// The latency is set by the three register stages: divide by 25, leap and
// range check, then date step and ordinal sum.
// Busy is high only during reset, which clears the stage valid bits.
// The response side cannot stall, so the pipeline never holds.
module calendar_date_unit_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [4:0]  req_day,
   input  logic [3:0]  req_month,
   input  logic signed [15:0] req_year,
   output logic        rsp_strobe,
   output logic        rsp_date_valid,
   output logic [4:0]  rsp_result_day,
   output logic [3:0]  rsp_result_month,
   output logic signed [15:0] rsp_result_year,
   output logic [8:0]  rsp_ordinal_day
);

   cdu_pkg::req_type req;
   cdu_pkg::s1_type  s1;
   cdu_pkg::s2_type  s2;
   cdu_pkg::rsp_type rsp;
   logic             beat_in;

   assign busy      = reset;
   assign beat_in   = start && !busy;
   assign req.mode  = cdu_pkg::mode_type'(req_mode);
   assign req.day   = req_day;
   assign req.month = req_month;
   assign req.year  = req_year;

   cdu_div25 u_div25 (
      .clock   (clock),
      .reset   (reset),
      .beat_in (beat_in),
      .req     (req),
      .s1      (s1)
   );

   cdu_check u_check (
      .clock (clock),
      .reset (reset),
      .s1    (s1),
      .s2    (s2)
   );

   cdu_step u_step (
      .clock (clock),
      .reset (reset),
      .s2    (s2),
      .rsp   (rsp)
   );

   assign rsp_strobe       = rsp.vld;
   assign rsp_date_valid   = rsp.date_valid;
   assign rsp_result_day   = rsp.result_day;
   assign rsp_result_month = rsp.result_month;
   assign rsp_result_year  = rsp.result_year;
   assign rsp_ordinal_day  = rsp.ordinal_day;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      beat_in |-> ##3 rsp_strobe)
      else $error("accepted beat did not produce a result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(beat_in, 3))
      else $error("result without an accepted beat");

endmodule

// File: tb/calendar_date_unit_top_test.sv
`timescale 1ns / 1ps

module calendar_date_unit_top_test;

   typedef struct packed {
      logic        valid;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [15:0] year;
      logic [8:0]  ordinal;
   } date_result_type;

   typedef struct packed {
      cdu_pkg::mode_type mode;
      logic [4:0]        day;
      logic [3:0]        month;
      logic [15:0]       year;
      logic              typed;
      date_result_type   want;
   } date_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_mode = cdu_pkg::MODE_VALIDATE;
   logic [4:0]  req_day = 5'd0;
   logic [3:0]  req_month = 4'd0;
   logic signed [15:0] req_year = 16'sd0;
   logic        rsp_strobe;
   logic        rsp_date_valid;
   logic [4:0]  rsp_result_day;
   logic [3:0]  rsp_result_month;
   logic signed [15:0] rsp_result_year;
   logic [8:0]  rsp_ordinal_day;

   logic            req_typed = 1'b0;
   date_result_type req_want = '0;

   date_result_type expected_dates[$];
   int              mismatches = 0;
   int              dates_sent = 0;
   int              results_seen = 0;
   int              valid_results = 0;
   int              mode_count[4] = '{0, 0, 0, 0};

   calendar_date_unit_top dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_day          (req_day),
      .req_month        (req_month),
      .req_year         (req_year),
      .rsp_strobe       (rsp_strobe),
      .rsp_date_valid   (rsp_date_valid),
      .rsp_result_day   (rsp_result_day),
      .rsp_result_month (rsp_result_month),
      .rsp_result_year  (rsp_result_year),
      .rsp_ordinal_day  (rsp_ordinal_day)
   );

   always #5 clock = ~clock;

   function automatic bit leap_year(logic [15:0] y);
      int unsigned v;
      v = y;
      return (v % 400 == 0) || ((v % 4 == 0) && (v % 100 != 0));
   endfunction

   function automatic logic [4:0] month_length(logic [3:0] m, logic [15:0] y);
      unique case (m)
         4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
         cdu_pkg::MONTH_FEB:      return leap_year(y) ? 5'd29 : 5'd28;
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 5'd31;
         default:                 return 5'd0;
      endcase
   endfunction

   function automatic date_result_type step_date(cdu_pkg::mode_type md, logic [4:0] d,
                                                 logic [3:0] m, logic [15:0] y);
      date_result_type r;
      logic            ok;
      logic [8:0]      sum;
      r = '{1'b1, d, m, y, 9'd0};
      ok = !y[15] && m >= 4'd1 && m <= cdu_pkg::MONTHS_PER_YEAR && d >= 5'd1 &&
           d <= month_length(m, y);
      if (ok) begin
         case (md)
            cdu_pkg::MODE_PREV: begin
               if (d > 5'd1) begin
                  r.day = d - 5'd1;
               end else if (m > 4'd1) begin
                  r.month = m - 4'd1;
                  r.day = month_length(m - 4'd1, y);
               end else begin
                  r.month = cdu_pkg::MONTHS_PER_YEAR;
                  r.day = cdu_pkg::DECEMBER_DAYS;
                  r.year = y - 16'd1;
               end
            end
            cdu_pkg::MODE_NEXT: begin
               if (d < month_length(m, y)) begin
                  r.day = d + 5'd1;
               end else if (m < cdu_pkg::MONTHS_PER_YEAR) begin
                  r.day = 5'd1;
                  r.month = m + 4'd1;
               end else if (y == cdu_pkg::YEAR_MAX) begin
                  ok = 1'b0;
               end else begin
                  r.day = 5'd1;
                  r.month = 4'd1;
                  r.year = y + 16'd1;
               end
            end
            cdu_pkg::MODE_ORDINAL: begin
               sum = 9'(d);
               for (int k = 1; k < m; k++)
                  sum += 9'(month_length(4'(k), y));
               r.ordinal = sum;
            end
            default: ;
         endcase
      end
      if (!ok)
         r = '0;
      return r;
   endfunction

   task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      date_result_type want;
      date_result_type got;
      if (rsp_strobe === 1'b1) begin
         results_seen++;
         got = '{rsp_date_valid, rsp_result_day, rsp_result_month, rsp_result_year,
                 rsp_ordinal_day};
         if (expected_dates.size() == 0) begin
            mismatches++;
            $display("%0t: result with nothing expected, got 0x%0h", $time, got);
         end else begin
            want = expected_dates.pop_front();
            if (got.valid === 1'b1)
               valid_results++;
            compare_field("date_valid", 16'(want.valid), 16'(got.valid));
            compare_field("result_day", 16'(want.day), 16'(got.day));
            compare_field("result_month", 16'(want.month), 16'(got.month));
            compare_field("result_year", want.year, got.year);
            compare_field("ordinal_day", 16'(want.ordinal), 16'(got.ordinal));
         end
      end
      if (start && busy === 1'b0) begin
         dates_sent++;
         mode_count[req_mode]++;
         expected_dates.push_back(req_typed ? req_want :
            step_date(cdu_pkg::mode_type'(req_mode), req_day, req_month, req_year));
      end
   end

   task automatic send_date(cdu_pkg::mode_type md, logic [4:0] d, logic [3:0] m,
                            logic [15:0] y, logic typed, date_result_type want,
                            int idle_pct);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      req_mode <= md;
      req_day <= d;
      req_month <= m;
      req_year <= y;
      req_typed <= typed;
      req_want <= want;
      start <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic send_random(int idle_pct);
      int                pick;
      cdu_pkg::mode_type md;
      logic [3:0]        m;
      logic [4:0]        d;
      logic [4:0]        len;
      logic [15:0]       y;
      pick = $urandom_range(0, 99);
      md = cdu_pkg::mode_type'(2'($urandom_range(0, 3)));
      case ($urandom_range(0, 5))
         0:       y = 16'($urandom_range(0, 32767));
         1:       y = 16'(400 * $urandom_range(0, 81));
         2:       y = 16'(100 * $urandom_range(0, 327));
         3:       y = 16'(4 * $urandom_range(0, 8191));
         4:       y = 16'($urandom_range(0, 3));
         default: y = cdu_pkg::YEAR_MAX - 16'($urandom_range(0, 3));
      endcase
      m = 4'($urandom_range(1, 12));
      len = month_length(m, y);
      case ($urandom_range(0, 3))
         0:       d = 5'd1;
         1:       d = len;
         2:       d = len - 5'd1;
         default: d = 5'($urandom_range(1, len));
      endcase
      if (pick >= 90) begin
         d = 5'($urandom);
         m = 4'($urandom);
         y = 16'($urandom);
      end else if (pick >= 75) begin
         case ($urandom_range(0, 3))
            0:       d = 5'd0;
            1:       d = (len < 5'd31) ? 5'($urandom_range(len + 1, 31)) : 5'd0;
            2:       m = ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(13, 15));
            default: y = y | 16'h8000;
         endcase
      end
      send_date(md, d, m, y, 1'b0, '0, idle_pct);
   endtask

   task automatic drain_dates();
      start <= 1'b0;
      @(posedge clock);
      while (expected_dates.size() != 0) @(posedge clock);
   endtask

   initial begin
      date_row_type plan [25];
      int           idle_plan [3];
      idle_plan = '{16, 55, 0};
      plan = '{
         '{cdu_pkg::MODE_VALIDATE, 5'd1,  4'd1,  16'd0,     1'b1,
           '{1'b1, 5'd1, 4'd1, 16'd0, 9'd0}},
         '{cdu_pkg::MODE_VALIDATE, 5'd31, 4'd12, 16'h7FFF,  1'b1,
           '{1'b1, 5'd31, 4'd12, 16'h7FFF, 9'd0}},
         '{cdu_pkg::MODE_VALIDATE, 5'd0,  4'd1,  16'd2000,  1'b1, '0},
         '{cdu_pkg::MODE_VALIDATE, 5'd31, 4'd15, 16'd2000,  1'b1, '0},
         '{cdu_pkg::MODE_VALIDATE, 5'd1,  4'd0,  16'd2000,  1'b1, '0},
         '{cdu_pkg::MODE_VALIDATE, 5'd1,  4'd1,  16'hFFFF,  1'b1, '0},
         '{cdu_pkg::MODE_VALIDATE, 5'd15, 4'd6,  16'h8000,  1'b1, '0},
         '{cdu_pkg::MODE_VALIDATE, 5'd29, 4'd2,  16'd2000,  1'b0, '0},
         '{cdu_pkg::MODE_VALIDATE, 5'd29, 4'd2,  16'd1900,  1'b1, '0},
         '{cdu_pkg::MODE_VALIDATE, 5'd29, 4'd2,  16'd2024,  1'b0, '0},
         '{cdu_pkg::MODE_ORDINAL,  5'd31, 4'd4,  16'd2021,  1'b1, '0},
         '{cdu_pkg::MODE_PREV,     5'd1,  4'd1,  16'd0,     1'b1,
           '{1'b1, 5'd31, 4'd12, 16'hFFFF, 9'd0}},
         '{cdu_pkg::MODE_PREV,     5'd1,  4'd3,  16'd2000,  1'b0, '0},
         '{cdu_pkg::MODE_PREV,     5'd1,  4'd3,  16'd1900,  1'b0, '0},
         '{cdu_pkg::MODE_PREV,     5'd0,  4'd13, 16'hFFFF,  1'b1, '0},
         '{cdu_pkg::MODE_PREV,     5'd17, 4'd8,  16'd1234,  1'b0, '0},
         '{cdu_pkg::MODE_NEXT,     5'd31, 4'd12, 16'h7FFF,  1'b1, '0},
         '{cdu_pkg::MODE_NEXT,     5'd31, 4'd12, 16'd1999,  1'b0, '0},
         '{cdu_pkg::MODE_NEXT,     5'd28, 4'd2,  16'd2000,  1'b0, '0},
         '{cdu_pkg::MODE_NEXT,     5'd28, 4'd2,  16'd2100,  1'b0, '0},
         '{cdu_pkg::MODE_NEXT,     5'd30, 4'd4,  16'd2023,  1'b0, '0},
         '{cdu_pkg::MODE_ORDINAL,  5'd1,  4'd1,  16'd0,     1'b1,
           '{1'b1, 5'd1, 4'd1, 16'd0, 9'd1}},
         '{cdu_pkg::MODE_ORDINAL,  5'd31, 4'd12, 16'd2000,  1'b1,
           '{1'b1, 5'd31, 4'd12, 16'd2000, 9'd366}},
         '{cdu_pkg::MODE_ORDINAL,  5'd1,  4'd3,  16'd2024,  1'b0, '0},
         '{cdu_pkg::MODE_ORDINAL,  5'd31, 4'd12, 16'd2023,  1'b0, '0}
      };
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      foreach (plan[i])
         send_date(plan[i].mode, plan[i].day, plan[i].month, plan[i].year,
                   plan[i].typed, plan[i].want, 16);
      // Hold the request side off until the pipeline has fully emptied.
      drain_dates();
      foreach (idle_plan[p]) begin
         repeat (400) send_random(idle_plan[p]);
         drain_dates();
      end
      repeat (8) @(posedge clock);
      $display("Sent %0d dates: %0d validate, %0d previous day, %0d next day, %0d ordinal.",
               dates_sent, mode_count[0], mode_count[1], mode_count[2], mode_count[3]);
      $display("Checked %0d results, %0d of them valid dates, with %0d mismatches.",
               results_seen, valid_results, mismatches);
      if (mismatches == 0)
         $display("calendar_date_unit_top regression: pass");
      else
         $display("calendar_date_unit_top regression: fail");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timed out with %0d results still expected.", expected_dates.size());
      $display("calendar_date_unit_top regression: fail");
      $finish;
   end

endmodule
